[hdl/dfa_pkg.sv]
// ---------------------------------------------------------------------------
// dfa_pkg
// Shared types, codes and constants of the decimal floating-point unit.
// ---------------------------------------------------------------------------
package dfa_pkg;

  localparam int DIGITS_DEFAULT = 16;
  localparam int MAX_DIGITS     = 16;
  localparam int CNT_W          = 5;
  localparam int EXP_W          = 20;

  localparam logic signed [EXP_W-1:0] EXP_MAX = EXP_W'(32767);
  localparam logic signed [EXP_W-1:0] EXP_MIN = -EXP_W'(32768);
  localparam logic signed [EXP_W-1:0] DIV_EXP_MAX = EXP_W'(32766);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_DIV_ZERO  = 2'd1;
  localparam logic [1:0] ERR_EXP_RANGE = 2'd2;

  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NRM,
    ST_SETUP,
    ST_ALN,
    ST_ADD,
    ST_MUL,
    ST_DIV,
    ST_SKIP,
    ST_RND,
    ST_TRIM,
    ST_FIN
  } state_t;

  // one operand after decoding, digits left-justified in 64 bits
  typedef struct packed {
    logic                     zero;
    logic                     neg;
    logic [CNT_W-1:0]         cnt;
    logic signed [EXP_W-1:0]  exp;
    logic [4*MAX_DIGITS-1:0]  dig;
  } opnd_t;

  function automatic logic [3:0] clamp_digit(input logic [3:0] nib);
    clamp_digit = (nib > 4'd9) ? 4'd9 : nib;
  endfunction

endpackage

[hdl/dfa_unpack.sv]
// ---------------------------------------------------------------------------
// dfa_unpack
// Decodes one operand beat: digit clamp, count limit, zero and sign detect.
// ---------------------------------------------------------------------------
module dfa_unpack #(
  parameter int DIGITS = dfa_pkg::DIGITS_DEFAULT
) (
  input  logic [1:0]         sign,
  input  logic [4:0]         count,
  input  logic [15:0]        exponent,
  input  logic [63:0]        digits,
  output dfa_pkg::opnd_t     opnd
);

  logic [dfa_pkg::CNT_W-1:0] n;
  logic [63:0]               dig;

  always_comb begin
    n = (count > dfa_pkg::CNT_W'(DIGITS)) ? dfa_pkg::CNT_W'(DIGITS) : count;
    for (int i = 0; i < dfa_pkg::MAX_DIGITS; i++) begin
      dig[63-4*i -: 4] = (i < n) ? dfa_pkg::clamp_digit(digits[63-4*i -: 4]) : 4'd0;
    end
  end

  always_comb begin
    opnd.zero = (sign == dfa_pkg::SIGN_ZERO) || (n == '0) || (dig == '0);
    opnd.neg  = sign[1];
    opnd.cnt  = n;
    opnd.exp  = dfa_pkg::EXP_W'($signed(exponent));
    opnd.dig  = dig;
  end

endmodule

[hdl/dfa_bcd_adder.sv]
// ---------------------------------------------------------------------------
// dfa_bcd_adder
// Wide BCD adder with optional nines complement of y, carry by prefix add.
// ---------------------------------------------------------------------------
module dfa_bcd_adder #(
  parameter int NDIG = 48
) (
  input  logic [4*NDIG-1:0] x,
  input  logic [4*NDIG-1:0] y,
  input  logic              inv,
  input  logic              cin,
  output logic [4*NDIG-1:0] sum,
  output logic              cout
);

  logic [4:0]      t    [NDIG];
  logic [NDIG-1:0] gen;
  logic [NDIG-1:0] prop;
  logic [NDIG:0]   chain;
  logic [4:0]      s;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      t[i]    = {1'b0, x[4*i +: 4]} +
                {1'b0, (inv ? (4'd9 - y[4*i +: 4]) : y[4*i +: 4])};
      gen[i]  = (t[i] > 5'd9);
      prop[i] = (t[i] == 5'd9);
    end
  end

  // generate digits add, propagate digits pass: carry into digit i is chain ^ prop
  assign chain = {1'b0, gen} + {1'b0, gen | prop} + {{NDIG{1'b0}}, cin};
  assign cout  = chain[NDIG];

  always_comb begin
    s = '0;
    for (int i = 0; i < NDIG; i++) begin
      s = t[i] + {4'd0, chain[i] ^ prop[i]};
      sum[4*i +: 4] = (s > 5'd9) ? 4'(s - 5'd10) : s[3:0];
    end
  end

endmodule

[hdl/decimal_float_arithmetic_unit.sv]
// ---------------------------------------------------------------------------
// decimal_float_arithmetic_unit
// Decimal add, subtract, multiply and divide on sign/magnitude BCD numbers.
// ---------------------------------------------------------------------------
// One operation at a time: in_ready is high only while the unit is idle, and
// a finished result waits in the output register so the next beat can be taken.
// All arithmetic runs through one 3*DIGITS-digit BCD adder, one add or trial
// subtract per cycle. Latency is data dependent: leading zeros are normalized
// away, addends are aligned, multiply adds a once per unit of each digit of b,
// divide finds DIGITS+1 quotient digits by repeated trial subtraction, and the
// result then loses its leading zeros, is rounded and has trailing zeros trimmed.
module decimal_float_arithmetic_unit #(
  parameter int DIGITS = dfa_pkg::DIGITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_a_sign,
  input  logic [4:0]  in_a_count,
  input  logic [15:0] in_a_exponent,
  input  logic [63:0] in_a_digits,
  input  logic [1:0]  in_b_sign,
  input  logic [4:0]  in_b_count,
  input  logic [15:0] in_b_exponent,
  input  logic [63:0] in_b_digits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_sign,
  output logic [4:0]  out_result_count,
  output logic [15:0] out_result_exponent,
  output logic [63:0] out_result_digits,
  output logic [1:0]  out_error_code
);

  localparam int SP  = 3 * DIGITS;
  localparam int SW  = 4 * SP;
  localparam int DW  = 4 * DIGITS;
  localparam int SPW = $clog2(SP + 1);
  localparam int CW  = $clog2(DIGITS + 1);
  localparam int EW  = dfa_pkg::EXP_W;
  localparam int QB  = 4 * (DIGITS + 1);
  localparam logic signed [EW-1:0] SP_E  = EW'(SP);
  localparam logic signed [EW-1:0] SPM_E = EW'(SP - 2);

  dfa_pkg::state_t state_r, state_nxt;

  dfa_pkg::opnd_t ua, ub;
  dfa_pkg::opnd_t a_r, a_nxt, b_r, b_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [1:0]          err_r, err_nxt;
  logic [SW-1:0]       acc_r, acc_nxt, opd_r, opd_nxt;
  logic [SPW-1:0]      sha_r, sha_nxt, shb_r, shb_nxt;
  logic [SPW-1:0]      fn_r, fn_nxt;
  logic signed [EW-1:0] fe_r, fe_nxt;
  logic                fneg_r, fneg_nxt, fzero_r, fzero_nxt;
  logic [DW-1:0]       mulb_r, mulb_nxt;
  logic [CW-1:0]       cntb_r, cntb_nxt;
  logic [3:0]          rep_r, rep_nxt;
  logic [3:0]          qd_r, qd_nxt;
  logic [CW-1:0]       qi_r, qi_nxt;
  logic [QB-1:0]       q_r, q_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  osign_r, osign_nxt, oerr_r, oerr_nxt;
  logic [4:0]  ocnt_r, ocnt_nxt;
  logic [15:0] oexp_r, oexp_nxt;
  logic [63:0] odig_r, odig_nxt;

  // adder port
  logic [SW-1:0] ax, ay, asum;
  logic          ainv, acin, acout;

  // control flags
  logic                 accept, nrm_done, a_lead0, b_lead0;
  logic                 out_free;
  logic signed [EW-1:0] ea, eb, hi, lo, loa, lob, span, sa, sb, ediv;
  logic [SPW-1:0]       n_add, sa_cap, sb_cap;
  logic [DW-1:0]        adig, bdig;
  logic                 div_lt, div_range;
  logic [SW-1:0]        amask, kmask, inc, la, lb;
  logic                 la_gt, la_eq;
  logic [CW-1:0]        keep, tidx;
  logic [3:0]           td [DIGITS+1];
  logic                 rnd;
  logic [3:0]           mdig;
  logic                 mul_step_last, div_last;
  logic signed [EW-1:0] fe_sat;

  dfa_unpack #(.DIGITS(DIGITS)) u_unpack_a (
    .sign(in_a_sign), .count(in_a_count), .exponent(in_a_exponent),
    .digits(in_a_digits), .opnd(ua)
  );

  dfa_unpack #(.DIGITS(DIGITS)) u_unpack_b (
    .sign(in_b_sign), .count(in_b_count), .exponent(in_b_exponent),
    .digits(in_b_digits), .opnd(ub)
  );

  dfa_bcd_adder #(.NDIG(SP)) u_adder (
    .x(ax), .y(ay), .inv(ainv), .cin(acin), .sum(asum), .cout(acout)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == dfa_pkg::ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // flags and setup arithmetic
  always_comb begin
    a_lead0  = !a_r.zero && (a_r.dig[63:60] == 4'd0);
    b_lead0  = !b_r.zero && (b_r.dig[63:60] == 4'd0);
    nrm_done = !a_lead0 && !b_lead0;
    adig     = a_r.dig[63 -: DW];
    bdig     = b_r.dig[63 -: DW];
    ea       = a_r.exp;
    eb       = b_r.exp;
    hi       = (ea > eb) ? ea : eb;
    loa      = ea - $signed({{(EW-dfa_pkg::CNT_W){1'b0}}, a_r.cnt}) + EW'(1);
    lob      = eb - $signed({{(EW-dfa_pkg::CNT_W){1'b0}}, b_r.cnt}) + EW'(1);
    lo       = (loa < lob) ? loa : lob;
    span     = hi - lo;
    n_add    = (span > SPM_E) ? SPW'(SP) : SPW'(span + EW'(2));
    sa       = hi - ea + EW'(1);
    sb       = hi - eb + EW'(1);
    sa_cap   = (sa > SP_E) ? SPW'(SP) : SPW'(sa);
    sb_cap   = (sb > SP_E) ? SPW'(SP) : SPW'(sb);
    div_lt   = (adig < bdig);
    ediv     = ea - eb - EW'(div_lt);
    div_range = (ediv < dfa_pkg::EXP_MIN) || (ediv > dfa_pkg::DIV_EXP_MAX);
    keep     = (fn_r > SPW'(DIGITS)) ? CW'(DIGITS) : CW'(fn_r);
    tidx     = CW'(fn_r - SPW'(1));
    for (int i = 0; i <= DIGITS; i++) begin
      td[i] = acc_r[SW-1-4*i -: 4];
    end
    for (int i = 0; i < SP; i++) begin
      amask[SW-1-4*i -: 4] = (i < fn_r) ? 4'hF : 4'h0;
      kmask[SW-1-4*i -: 4] = (i < keep) ? 4'hF : 4'h0;
      inc[SW-1-4*i -: 4]   = (i + 1 == keep) ? 4'd1 : 4'd0;
    end
    rnd   = (fn_r > SPW'(keep)) && (td[keep] >= 4'd5);
    la    = acc_r & amask;
    lb    = opd_r & amask;
    la_gt = (la > lb);
    la_eq = (la == lb);
    mdig  = mulb_r[DW-1 -: 4];
    mul_step_last = (rep_r == mdig) && (cntb_r == CW'(1));
    div_last      = !acout && (qi_r == CW'(DIGITS));
    fe_sat = (fe_r > dfa_pkg::EXP_MAX) ? dfa_pkg::EXP_MAX :
             (fe_r < dfa_pkg::EXP_MIN) ? dfa_pkg::EXP_MIN : fe_r;
  end

  // shared adder operand select
  always_comb begin
    ax   = acc_r;
    ay   = opd_r;
    ainv = 1'b0;
    acin = 1'b0;
    case (state_r)
      dfa_pkg::ST_ADD: begin
        if (a_r.neg == b_r.neg) begin
          ax = la;
          ay = lb;
        end else begin
          ax   = la_gt ? la : lb;
          ay   = la_gt ? lb : la;
          ainv = 1'b1;
          acin = 1'b1;
        end
      end
      dfa_pkg::ST_DIV: begin
        ainv = 1'b1;
        acin = 1'b1;
      end
      dfa_pkg::ST_RND: begin
        ax = acc_r & kmask;
        ay = rnd ? inc : '0;
      end
      default: begin
        ax = acc_r;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dfa_pkg::ST_IDLE:  if (accept) state_nxt = dfa_pkg::ST_NRM;
      dfa_pkg::ST_NRM:   if (nrm_done) state_nxt = dfa_pkg::ST_SETUP;
      dfa_pkg::ST_SETUP: begin
        unique case (dfa_pkg::op_t'(op_r))
          dfa_pkg::OP_ADD, dfa_pkg::OP_SUB: begin
            if (a_r.zero && b_r.zero) state_nxt = dfa_pkg::ST_FIN;
            else if (a_r.zero || b_r.zero) state_nxt = dfa_pkg::ST_SKIP;
            else state_nxt = dfa_pkg::ST_ALN;
          end
          dfa_pkg::OP_MUL: begin
            state_nxt = (a_r.zero || b_r.zero) ? dfa_pkg::ST_FIN : dfa_pkg::ST_MUL;
          end
          dfa_pkg::OP_DIV: begin
            state_nxt = (a_r.zero || b_r.zero || div_range) ? dfa_pkg::ST_FIN :
                        dfa_pkg::ST_DIV;
          end
          default: state_nxt = dfa_pkg::ST_FIN;
        endcase
      end
      dfa_pkg::ST_ALN:  if (sha_r == '0 && shb_r == '0) state_nxt = dfa_pkg::ST_ADD;
      dfa_pkg::ST_ADD: begin
        state_nxt = (a_r.neg != b_r.neg && la_eq) ? dfa_pkg::ST_FIN : dfa_pkg::ST_SKIP;
      end
      dfa_pkg::ST_MUL:  if (mul_step_last) state_nxt = dfa_pkg::ST_SKIP;
      dfa_pkg::ST_DIV:  if (div_last) state_nxt = dfa_pkg::ST_SKIP;
      dfa_pkg::ST_SKIP: begin
        if (fn_r == '0) state_nxt = dfa_pkg::ST_FIN;
        else if (td[0] != 4'd0) state_nxt = dfa_pkg::ST_RND;
      end
      dfa_pkg::ST_RND:  state_nxt = dfa_pkg::ST_TRIM;
      dfa_pkg::ST_TRIM: begin
        if (!(fn_r > SPW'(1) && td[tidx] == 4'd0)) state_nxt = dfa_pkg::ST_FIN;
      end
      dfa_pkg::ST_FIN:  if (out_free) state_nxt = dfa_pkg::ST_IDLE;
      default:          state_nxt = dfa_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    a_nxt = a_r;  b_nxt = b_r;  op_nxt = op_r;  err_nxt = err_r;
    acc_nxt = acc_r;  opd_nxt = opd_r;  sha_nxt = sha_r;  shb_nxt = shb_r;
    fn_nxt = fn_r;  fe_nxt = fe_r;  fneg_nxt = fneg_r;  fzero_nxt = fzero_r;
    mulb_nxt = mulb_r;  cntb_nxt = cntb_r;  rep_nxt = rep_r;
    qd_nxt = qd_r;  qi_nxt = qi_r;  q_nxt = q_r;
    osign_nxt = osign_r;  ocnt_nxt = ocnt_r;  oexp_nxt = oexp_r;
    odig_nxt = odig_r;  oerr_nxt = oerr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      dfa_pkg::ST_IDLE: begin
        if (accept) begin
          a_nxt     = ua;
          b_nxt     = ub;
          b_nxt.neg = ub.neg ^ (in_operation == dfa_pkg::OP_SUB);
          op_nxt    = in_operation;
          err_nxt   = dfa_pkg::ERR_NONE;
          fzero_nxt = 1'b0;
        end
      end
      dfa_pkg::ST_NRM: begin
        // skip leading zero digits, one per cycle
        if (a_lead0) begin
          a_nxt.dig = a_r.dig << 4;
          a_nxt.cnt = a_r.cnt - dfa_pkg::CNT_W'(1);
          a_nxt.exp = a_r.exp - EW'(1);
        end
        if (b_lead0) begin
          b_nxt.dig = b_r.dig << 4;
          b_nxt.cnt = b_r.cnt - dfa_pkg::CNT_W'(1);
          b_nxt.exp = b_r.exp - EW'(1);
        end
      end
      dfa_pkg::ST_SETUP: begin
        unique case (dfa_pkg::op_t'(op_r))
          dfa_pkg::OP_ADD, dfa_pkg::OP_SUB: begin
            if (a_r.zero) begin
              acc_nxt   = {bdig, {(SW-DW){1'b0}}};
              fn_nxt    = SPW'(b_r.cnt);
              fe_nxt    = eb;
              fneg_nxt  = b_r.neg;
              fzero_nxt = b_r.zero;
            end else if (b_r.zero) begin
              acc_nxt  = {adig, {(SW-DW){1'b0}}};
              fn_nxt   = SPW'(a_r.cnt);
              fe_nxt   = ea;
              fneg_nxt = a_r.neg;
            end else begin
              acc_nxt = {adig, {(SW-DW){1'b0}}};
              opd_nxt = {bdig, {(SW-DW){1'b0}}};
              sha_nxt = sa_cap;
              shb_nxt = sb_cap;
              fn_nxt  = n_add;
              fe_nxt  = hi + EW'(1);
            end
          end
          dfa_pkg::OP_MUL: begin
            fzero_nxt = a_r.zero || b_r.zero;
            acc_nxt   = '0;
            opd_nxt   = {4'd0, adig, {(SW-DW-4){1'b0}}};
            mulb_nxt  = bdig;
            cntb_nxt  = CW'(b_r.cnt);
            rep_nxt   = '0;
            fn_nxt    = SPW'(a_r.cnt) + SPW'(b_r.cnt);
            fe_nxt    = ea + eb + EW'(1);
            fneg_nxt  = a_r.neg ^ b_r.neg;
          end
          dfa_pkg::OP_DIV: begin
            fzero_nxt = a_r.zero || b_r.zero || div_range;
            if (b_r.zero) err_nxt = dfa_pkg::ERR_DIV_ZERO;
            else if (!a_r.zero && div_range) err_nxt = dfa_pkg::ERR_EXP_RANGE;
            // remainder starts one digit above the divisor when it is smaller
            acc_nxt  = div_lt ? {adig, {(SW-DW){1'b0}}} :
                                {4'd0, adig, {(SW-DW-4){1'b0}}};
            opd_nxt  = {4'd0, bdig, {(SW-DW-4){1'b0}}};
            qd_nxt   = '0;
            qi_nxt   = '0;
            fn_nxt   = SPW'(DIGITS + 1);
            fe_nxt   = ediv;
            fneg_nxt = a_r.neg ^ b_r.neg;
          end
          default: fzero_nxt = 1'b1;
        endcase
      end
      dfa_pkg::ST_ALN: begin
        if (sha_r != '0) begin
          acc_nxt = acc_r >> 4;
          sha_nxt = sha_r - SPW'(1);
        end
        if (shb_r != '0) begin
          opd_nxt = opd_r >> 4;
          shb_nxt = shb_r - SPW'(1);
        end
      end
      dfa_pkg::ST_ADD: begin
        acc_nxt = asum;
        if (a_r.neg == b_r.neg) fneg_nxt = a_r.neg;
        else begin
          fneg_nxt  = la_gt ? a_r.neg : b_r.neg;
          fzero_nxt = la_eq;
        end
      end
      dfa_pkg::ST_MUL: begin
        // add the shifted multiplicand once per unit of the current digit
        if (rep_r != mdig) begin
          acc_nxt = asum;
          rep_nxt = rep_r + 4'd1;
        end else begin
          rep_nxt  = '0;
          opd_nxt  = opd_r >> 4;
          mulb_nxt = mulb_r << 4;
          cntb_nxt = cntb_r - CW'(1);
        end
      end
      dfa_pkg::ST_DIV: begin
        if (acout) begin
          acc_nxt = asum;
          qd_nxt  = qd_r + 4'd1;
        end else begin
          q_nxt   = {q_r[QB-5:0], qd_r};
          qd_nxt  = '0;
          acc_nxt = acc_r << 4;
          qi_nxt  = qi_r + CW'(1);
          if (div_last) acc_nxt = {q_r[QB-5:0], qd_r, {(SW-QB){1'b0}}};
        end
      end
      dfa_pkg::ST_SKIP: begin
        if (fn_r == '0) fzero_nxt = 1'b1;
        else if (td[0] == 4'd0) begin
          acc_nxt = acc_r << 4;
          fn_nxt  = fn_r - SPW'(1);
          fe_nxt  = fe_r - EW'(1);
        end
      end
      dfa_pkg::ST_RND: begin
        if (acout) begin
          acc_nxt = {4'd1, {(SW-4){1'b0}}};
          fn_nxt  = SPW'(1);
          fe_nxt  = fe_r + EW'(1);
        end else begin
          acc_nxt = asum;
          fn_nxt  = SPW'(keep);
        end
      end
      dfa_pkg::ST_TRIM: begin
        if (fn_r > SPW'(1) && td[tidx] == 4'd0) fn_nxt = fn_r - SPW'(1);
      end
      dfa_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          oerr_nxt      = err_r;
          if (fzero_r) begin
            osign_nxt = dfa_pkg::SIGN_ZERO;
            ocnt_nxt  = '0;
            oexp_nxt  = '0;
            odig_nxt  = '0;
          end else begin
            osign_nxt = fneg_r ? dfa_pkg::SIGN_NEG : dfa_pkg::SIGN_POS;
            ocnt_nxt  = 5'(fn_r);
            oexp_nxt  = fe_sat[15:0];
            odig_nxt  = 64'(acc_r[SW-1 -: DW]) << (64 - DW);
          end
        end
      end
      default: begin
        fzero_nxt = fzero_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;  b_r <= b_nxt;  op_r <= op_nxt;  err_r <= err_nxt;
    acc_r <= acc_nxt;  opd_r <= opd_nxt;  sha_r <= sha_nxt;  shb_r <= shb_nxt;
    fn_r <= fn_nxt;  fe_r <= fe_nxt;  fneg_r <= fneg_nxt;  fzero_r <= fzero_nxt;
    mulb_r <= mulb_nxt;  cntb_r <= cntb_nxt;  rep_r <= rep_nxt;
    qd_r <= qd_nxt;  qi_r <= qi_nxt;  q_r <= q_nxt;
    osign_r <= osign_nxt;  ocnt_r <= ocnt_nxt;  oexp_r <= oexp_nxt;
    odig_r <= odig_nxt;  oerr_r <= oerr_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_result_sign     = osign_r;
  assign out_result_count    = ocnt_r;
  assign out_result_exponent = oexp_r;
  assign out_result_digits   = odig_r;
  assign out_error_code      = oerr_r;

endmodule

[hdl/dfa_checker.sv]
// ---------------------------------------------------------------------------
// dfa_checker
// Port-level checks of the decimal floating-point unit, bound to the top.
// ---------------------------------------------------------------------------
module dfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_sign,
  input logic [4:0]  out_result_count,
  input logic [63:0] out_result_digits,
  input logic [1:0]  out_error_code
);

  // one operation at a time
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("unit still ready after accepting a beat");

  a_zero_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result_sign == 2'b00) == (out_result_count == 5'd0)))
    else $error("zero sign and zero count disagree");

  a_error_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != 2'd0) |->
      (out_result_sign == 2'b00) && (out_result_digits == 64'd0))
    else $error("error result is not zero");

  a_error_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_code != 2'd3) && (out_result_sign != 2'b10))
    else $error("illegal error code or sign");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_digits))
    else $error("stalled result changed");

endmodule

bind decimal_float_arithmetic_unit dfa_checker u_dfa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_result_sign(out_result_sign), .out_result_count(out_result_count),
  .out_result_digits(out_result_digits), .out_error_code(out_error_code)
);
